// ===== design/assert_macros.svh =====
// assertion macros used by the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
// types and constants of the rotation matrix to quaternion converter
`default_nettype none
package rmq_pkg;

	localparam int DataW    = 16;
	localparam int RadW     = 62;
	localparam int RootW    = 31;
	localparam int MagW     = 45;
	localparam int NumW     = 46;
	localparam int DvsW     = 32;
	localparam int QuoBits  = 17;
	localparam int SqrtSteps = RootW;
	localparam int QOne     = 16384;

	typedef struct packed {
		logic                      degen;
		logic                      fault;
		logic [2:0]                neg;
		logic [2:0][MagW-1:0]      mag;
		logic [RadW-1:0]           rem;
		logic [RootW-1:0]          root;
	} sqrt_t;

	typedef struct packed {
		logic                      degen;
		logic                      fault;
		logic [2:0]                neg;
		logic [14:0]               w;
		logic [DvsW-1:0]           dvs;
		logic [2:0][NumW-1:0]      rem;
		logic [2:0][QuoBits-1:0]   quo;
		logic [2:0]                ovf;
	} div_t;

endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
// path to out_valid: stage 1, stage 2, the square root and quotient pipelines, output register
// throughput: one transaction per cycle while not stalled, fully pipelined
// depth is set by the 31-step square root and the 17-step quotient pipelines
// a stall holds the whole pipeline only while a result waits and the last stage is full
// arst_n clears all valid bits; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [DataW-1:0] r00,
	input  wire logic signed [DataW-1:0] r01,
	input  wire logic signed [DataW-1:0] r02,
	input  wire logic signed [DataW-1:0] r10,
	input  wire logic signed [DataW-1:0] r11,
	input  wire logic signed [DataW-1:0] r12,
	input  wire logic signed [DataW-1:0] r20,
	input  wire logic signed [DataW-1:0] r21,
	input  wire logic signed [DataW-1:0] r22,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [DataW-1:0]      q_w,
	output logic signed [DataW-1:0]      q_x,
	output logic signed [DataW-1:0]      q_y,
	output logic signed [DataW-1:0]      q_z,
	output logic                         used_degenerate,
	output logic                         fault
);

	logic pipe_en;

	// stage 1: trace, differences, squares and cross products
	logic               v_s1;
	logic signed [17:0] t_s1;
	logic signed [16:0] d_s1 [3];
	logic [30:0]        p_s1 [3];
	logic signed [31:0] m_s1 [3];
	logic signed [31:0] sq01, sq02, sq12;

	assign sq01 = 32'(r01) * 32'(r01);
	assign sq02 = 32'(r02) * 32'(r02);
	assign sq12 = 32'(r12) * 32'(r12);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (pipe_en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			t_s1    <= 18'(r00) + 18'(r11) + 18'(r22) + 18'(QOne);
			d_s1[0] <= 17'(r21) - 17'(r12);
			d_s1[1] <= 17'(r02) - 17'(r20);
			d_s1[2] <= 17'(r10) - 17'(r01);
			p_s1[0] <= sq01[30:0];
			p_s1[1] <= sq02[30:0];
			p_s1[2] <= sq12[30:0];
			m_s1[0] <= 32'(r02) * 32'(r01);
			m_s1[1] <= 32'(r01) * 32'(r12);
			m_s1[2] <= 32'(r02) * 32'(r12);
		end
	end

	// stage 2: branch choice, products of squares, numerator magnitudes
	logic                 v_s2;
	logic                 degen_s2;
	logic [16:0]          t_s2;
	logic [RadW-1:0]      a_s2, b_s2, c_s2;
	logic [2:0]           neg_s2;
	logic [2:0][MagW-1:0] mag_s2;
	logic                 degen_c;
	logic [2:0]           neg_c;
	logic [2:0][MagW-1:0] mag_c;

	assign degen_c = t_s1[17] || (t_s1 == '0);

	always_comb begin
		logic [15:0] dabs;
		logic [31:0] mabs;
		for (int i = 0; i < 3; i++) begin
			dabs = d_s1[i][16] ? 16'(-d_s1[i]) : d_s1[i][15:0];
			mabs = m_s1[i][31] ? 32'(-m_s1[i]) : 32'(m_s1[i]);
			if (degen_c) begin
				neg_c[i] = m_s1[i][31];
				mag_c[i] = MagW'(mabs) << 14;
			end else begin
				neg_c[i] = d_s1[i][16];
				mag_c[i] = MagW'(dabs) << 12;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (pipe_en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			degen_s2 <= degen_c;
			t_s2     <= t_s1[16:0];
			a_s2     <= RadW'(p_s1[0]) * RadW'(p_s1[1]);
			b_s2     <= RadW'(p_s1[0]) * RadW'(p_s1[2]);
			c_s2     <= RadW'(p_s1[1]) * RadW'(p_s1[2]);
			neg_s2   <= neg_c;
			mag_s2   <= mag_c;
		end
	end

	// stage 3 feeds the square root pipeline
	logic            sqrt_v [SqrtSteps+1];
	sqrt_t           sqrt_s [SqrtSteps+1];
	logic [RadW-1:0] s_sum;

	assign s_sum = a_s2 + b_s2 + c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqrt_v[0] <= 1'b0;
		else if (pipe_en) sqrt_v[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sqrt_s[0].degen <= degen_s2;
			sqrt_s[0].fault <= degen_s2 && (s_sum == '0);
			sqrt_s[0].neg   <= neg_s2;
			sqrt_s[0].mag   <= mag_s2;
			sqrt_s[0].rem   <= degen_s2 ? s_sum : (RadW'(t_s2) << 12);
			sqrt_s[0].root  <= '0;
		end
	end

	// one root bit per stage, most significant first
	for (genvar i = 1; i <= SqrtSteps; i++) begin : g_sqrt
		localparam int B = SqrtSteps - i;
		logic [RadW-1:0] trial;
		sqrt_t           step_c;

		assign trial = (RadW'(sqrt_s[i-1].root) << (B + 1)) + (RadW'(1) << (2 * B));

		always_comb begin
			step_c = sqrt_s[i-1];
			if (trial <= sqrt_s[i-1].rem) begin
				step_c.rem  = sqrt_s[i-1].rem - trial;
				step_c.root = sqrt_s[i-1].root | (RootW'(1) << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqrt_v[i] <= 1'b0;
			else if (pipe_en) sqrt_v[i] <= sqrt_v[i-1];
		end

		always_ff @(posedge clk) begin
			if (pipe_en) sqrt_s[i] <= step_c;
		end
	end

	// rounding numerators, divisor and overflow check
	logic  div_v [QuoBits+1];
	div_t  div_s [QuoBits+1];
	sqrt_t sq_last;
	logic [2:0][NumW-1:0] num_c;
	logic [DvsW-1:0]      dvs_c;
	logic [2:0]           ovf_c;

	assign sq_last = sqrt_s[SqrtSteps];
	assign dvs_c   = {sq_last.root, 1'b0};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NumW'(sq_last.mag[i]) << 1) + NumW'(sq_last.root);
			ovf_c[i] = (49'(num_c[i]) >= (49'(dvs_c) << QuoBits));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v[0] <= 1'b0;
		else if (pipe_en) div_v[0] <= sqrt_v[SqrtSteps];
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			div_s[0].degen <= sq_last.degen;
			div_s[0].fault <= sq_last.fault;
			div_s[0].neg   <= sq_last.neg;
			div_s[0].w     <= sq_last.root[14:0];
			div_s[0].dvs   <= dvs_c;
			div_s[0].rem   <= num_c;
			div_s[0].quo   <= '0;
			div_s[0].ovf   <= ovf_c;
		end
	end

	// one quotient bit per stage for all three components
	for (genvar j = 1; j <= QuoBits; j++) begin : g_div
		localparam int K = QuoBits - j;
		logic [47:0] shd;
		div_t        step_c;

		assign shd = 48'(div_s[j-1].dvs) << K;

		always_comb begin
			step_c = div_s[j-1];
			for (int c = 0; c < 3; c++) begin
				if (48'(div_s[j-1].rem[c]) >= shd) begin
					step_c.rem[c]    = div_s[j-1].rem[c] - NumW'(shd);
					step_c.quo[c][K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v[j] <= 1'b0;
			else if (pipe_en) div_v[j] <= div_v[j-1];
		end

		always_ff @(posedge clk) begin
			if (pipe_en) div_s[j] <= step_c;
		end
	end

	// sign, saturation and output register
	div_t                  dv_last;
	logic                  last_v;
	logic                  out_load;
	logic [2:0][DataW-1:0] comp_c;

	assign dv_last = div_s[QuoBits];
	assign last_v  = div_v[QuoBits];

	always_comb begin
		logic big;
		for (int c = 0; c < 3; c++) begin
			big = dv_last.ovf[c] || dv_last.quo[c][16] || dv_last.quo[c][15];
			if (dv_last.fault) comp_c[c] = '0;
			else if (dv_last.neg[c])
				comp_c[c] = big ? 16'h8000 : 16'(16'd0 - {1'b0, dv_last.quo[c][14:0]});
			else
				comp_c[c] = big ? 16'h7fff : {1'b0, dv_last.quo[c][14:0]};
		end
	end

	assign out_load = !out_valid || out_ready;
	assign pipe_en  = !(last_v && !out_load);
	assign in_ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= last_v;
	end

	always_ff @(posedge clk) begin
		if (out_load && last_v) begin
			q_w             <= dv_last.degen ? '0 : {1'b0, dv_last.w};
			q_x             <= comp_c[0];
			q_y             <= comp_c[1];
			q_z             <= comp_c[2];
			used_degenerate <= dv_last.degen;
			fault           <= dv_last.fault;
		end
	end

	`ASSERT_IMPL(a_fault_zero, out_valid && fault, used_degenerate && q_w == '0 && q_x == '0 && q_y == '0 && q_z == '0, "fault result not zero")
	`ASSERT_IMPL(a_normal_w, out_valid && !used_degenerate, q_w > 0 && !fault, "normal branch with zero scalar")
	`ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without waiting result")
	`ASSERT_NEXT(a_held, out_valid && !out_ready, out_valid && $stable(q_x) && $stable(fault), "waiting result changed")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the rotation matrix to quaternion converter
`default_nettype none
module testbench;
	import rmq_pkg::*;

	typedef struct {
		logic signed [15:0] r [9];
	} matrix_t;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		logic degen, flt;
	} quat_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [DataW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [DataW-1:0] q_w, q_x, q_y, q_z;
	logic used_degenerate, fault;

	matrix_t pending_q[$];
	quat_t quat_q[$];
	int errors = 0, n_in = 0, n_out = 0, n_degen = 0, n_fault = 0;
	bit stim_done = 0;
	int hold_off = 0;
	bit big_hold = 0;

	rotation_matrix_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22), .out_valid(out_valid), .out_ready(out_ready),
		.q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z),
		.used_degenerate(used_degenerate), .fault(fault)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, cand;
		res = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if (cand * cand <= n)
				res = cand;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag, q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic quat_t to_quaternion(matrix_t m);
		quat_t q;
		longint a[9];
		longint t, p01, p02, p12;
		longint unsigned w, s, den;
		for (int i = 0; i < 9; i++)
			a[i] = m.r[i];
		q = '{default: 0};
		t = a[0] + a[4] + a[8] + QOne;
		if (t > 0) begin
			w = int_sqrt(t * 4096);
			q.w = clip16(w);
			q.x = clip16(round_div((a[7] - a[5]) * 4096, w));
			q.y = clip16(round_div((a[2] - a[6]) * 4096, w));
			q.z = clip16(round_div((a[3] - a[1]) * 4096, w));
		end else begin
			p01 = a[1] * a[1];
			p02 = a[2] * a[2];
			p12 = a[5] * a[5];
			s = p01 * p02 + p01 * p12 + p02 * p12;
			q.degen = 1;
			if (s == 0)
				q.flt = 1;
			else begin
				den = int_sqrt(s);
				q.x = clip16(round_div(a[2] * a[1] * QOne, den));
				q.y = clip16(round_div(a[1] * a[5] * QOne, den));
				q.z = clip16(round_div(a[2] * a[5] * QOne, den));
			end
		end
		return q;
	endfunction

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 0;
			3: return $urandom_range(0, 32768) - 16384;
			default: return $urandom;
		endcase
	endfunction

	function automatic matrix_t rotation(int axis, int c, int s);
		matrix_t m;
		int i, j;
		foreach (m.r[k])
			m.r[k] = 0;
		i = (axis + 1) % 3;
		j = (axis + 2) % 3;
		m.r[axis * 4] = QOne;
		m.r[i * 4] = c;
		m.r[j * 4] = c;
		m.r[i * 3 + j] = -s;
		m.r[j * 3 + i] = s;
		return m;
	endfunction

	function automatic matrix_t flat(int v);
		matrix_t m;
		foreach (m.r[k])
			m.r[k] = v;
		return m;
	endfunction

	initial begin
		matrix_t m;
		int ang;
		pending_q.push_back(rotation(0, QOne, 0));
		pending_q.push_back(flat(0));
		pending_q.push_back(flat(-32768));
		pending_q.push_back(flat(32767));
		m = flat(0);
		m.r[0] = -QOne; m.r[4] = -QOne; m.r[8] = QOne;
		pending_q.push_back(m);
		m.r[1] = 100; m.r[2] = -200; m.r[5] = 300;
		pending_q.push_back(m);
		m = flat(-32768);
		m.r[8] = 16384;
		pending_q.push_back(m);
		for (int a = 0; a < 3; a++) begin
			pending_q.push_back(rotation(a, -QOne, 0));
			pending_q.push_back(rotation(a, 0, QOne));
			pending_q.push_back(rotation(a, 0, -QOne));
		end
		m = flat(32767);
		m.r[0] = -32768; m.r[4] = -32768; m.r[8] = -32768;
		pending_q.push_back(m);
		m = flat(-32768);
		m.r[0] = 32767; m.r[4] = 32767; m.r[8] = 32767;
		pending_q.push_back(m);
		m = flat(0);
		m.r[0] = 1; m.r[4] = -QOne; m.r[8] = -QOne;
		pending_q.push_back(m);
		repeat (450) begin
			case ($urandom_range(0, 3))
				0: foreach (m.r[k]) m.r[k] = $urandom;
				1: foreach (m.r[k]) m.r[k] = rand_entry();
				2: begin
					ang = $urandom_range(0, 16384);
					m = rotation($urandom_range(0, 2), QOne - ang,
						$urandom_range(0, 1) ? ang : -ang);
				end
				default: begin
					foreach (m.r[k]) m.r[k] = rand_entry();
					m.r[0] = -$urandom_range(0, 32768);
					m.r[4] = -$urandom_range(0, 32768);
					m.r[8] = $urandom_range(0, 16384);
					if ($urandom_range(0, 7) == 0)
						m.r[$urandom_range(0, 2) * 3 + 2 - $urandom_range(0, 1)] = 0;
				end
			endcase
			pending_q.push_back(m);
		end
		stim_done = 1;
	end

	// handshake seen at the rising edge
	logic in_ready_seen;

	// driver
	int in_gap = 0;
	matrix_t cur;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{r00, r01, r02, r10, r11, r12, r20, r21, r22} <= '0;
		end else if (!in_valid || in_ready_seen) begin
			if (in_gap > 0 || pending_q.size() == 0) begin
				in_gap <= (in_gap > 0) ? in_gap - 1 : 0;
				in_valid <= 0;
			end else begin
				cur = pending_q.pop_front();
				{r00, r01, r02} <= {cur.r[0], cur.r[1], cur.r[2]};
				{r10, r11, r12} <= {cur.r[3], cur.r[4], cur.r[5]};
				{r20, r21, r22} <= {cur.r[6], cur.r[7], cur.r[8]};
				in_valid <= 1;
				in_gap <= ($urandom_range(0, 2) == 0) ?
					(($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3)) : 0;
			end
		end
	end

	// accepted transactions also feed the predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_ready_seen <= 0;
		else begin
			in_ready_seen <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				quat_q.push_back(to_quaternion(
					'{r: '{r00, r01, r02, r10, r11, r12, r20, r21, r22}}));
				n_in++;
			end
		end
	end

	// receiver stalls, with one long hold-off once more than 60 matrices are accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (!big_hold && n_in > 60) begin
			big_hold <= 1;
			hold_off <= 150;
			out_ready <= 0;
		end else if ($urandom_range(0, 4) == 0) begin
			hold_off <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 2);
			out_ready <= 0;
		end else
			out_ready <= 1;
	end

	// monitor
	always @(posedge clk) begin
		quat_t e;
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (used_degenerate) n_degen++;
			if (fault) n_fault++;
			if (quat_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction: w=%0d x=%0d y=%0d z=%0d",
						q_w, q_x, q_y, q_z);
			end else begin
				e = quat_q.pop_front();
				if (q_w !== e.w || q_x !== e.x || q_y !== e.y || q_z !== e.z ||
						used_degenerate !== e.degen || fault !== e.flt) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch #%0d: exp w=%0d x=%0d y=%0d z=%0d d=%0b f=%0b",
							" got w=%0d x=%0d y=%0d z=%0d d=%0b f=%0b"},
							n_out, e.w, e.x, e.y, e.z, e.degen, e.flt,
							q_w, q_x, q_y, q_z, used_degenerate, fault);
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (stim_done && pending_q.size() == 0 && !in_valid);
		wait (quat_q.size() == 0);
		repeat (80) @(posedge clk);
		$display("%0d matrices converted, %0d degenerate, %0d with zero denominator",
			n_out, n_degen, n_fault);
		if (errors == 0 && quat_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#200000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
